FILE: rtl/ioc_pkg.sv
package ioc_pkg;

   // Sample layout: gyro x, y, z, then accel x, y, z.
   localparam int NUM_AXES        = 6;
   localparam int ACCEL_BASE      = 3;
   localparam int NUM_ACCEL       = 3;
   localparam int AXIS_Z_ACCEL    = 5;
   localparam int AXIS_IDX_W      = 3;
   localparam int WORD_W          = 16;

   // Averaging window and the widths that follow from it.
   localparam int AVERAGE_SAMPLES = 100;
   localparam int COUNT_W         = $clog2(AVERAGE_SAMPLES + 1);
   localparam int SUM_W           = 24;
   localparam int OFS_W           = 17;

   // Division by the window length is a multiply by a rounded-up reciprocal.
   localparam int RECIP_SHIFT              = 31;
   localparam int RECIP_W                  = RECIP_SHIFT + 1 - $clog2(AVERAGE_SAMPLES);
   localparam logic [32:0] RECIP_NUM       = 33'(1) << RECIP_SHIFT;
   localparam logic [32:0] RECIP_FULL      = (RECIP_NUM + 33'(AVERAGE_SAMPLES) - 33'(1))
                                             / 33'(AVERAGE_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
   localparam int PROD_W                   = SUM_W + RECIP_W;

   // Configuration registers.
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int THRESHOLD_W  = 16;
   localparam int RUN_W        = 8;
   localparam int GRAVITY_W    = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_RUN_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY_REFERENCE = 2'd2;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd400;
   localparam logic [RUN_W-1:0]       RUN_LENGTH_RESET = 8'd100;
   localparam logic [GRAVITY_W-1:0]   GRAVITY_RESET   = 15'd16384;
   localparam logic [RUN_W-1:0]       RUN_MAX         = 8'hFF;

   // Calibration phases.
   localparam logic [1:0] PHASE_WAIT = 2'd0;
   localparam logic [1:0] PHASE_AVG  = 2'd1;
   localparam logic [1:0] PHASE_DONE = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type [NUM_AXES-1:0]  word_vec_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [NUM_AXES-1:0]   sum_vec_type;
   typedef logic signed [OFS_W-1:0]  ofs_type;
   typedef ofs_type [NUM_AXES-1:0]   ofs_vec_type;

   // Status from the calibration core to the rest of the block.
   typedef struct packed {
      logic [1:0] phase;
      logic       div_start;
   } calib_status_type;

endpackage

FILE: rtl/ioc_calib_core.sv
module ioc_calib_core
   import ioc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  word_vec_type            sample,
   input  logic [THRESHOLD_W-1:0]  still_threshold,
   input  logic [RUN_W-1:0]        still_run_length,
   input  logic [GRAVITY_W-1:0]    gravity_reference,
   output calib_status_type        cal_stat,
   output sum_vec_type             sums
);

   logic [1:0]          phase_ff, phase_in;
   word_type [NUM_ACCEL-1:0] prev_ff, prev_in;
   logic [RUN_W-1:0]    run_ff, run_in, run_next;
   logic [COUNT_W-1:0]  count_ff, count_in;
   sum_vec_type         sums_ff, sums_in;
   logic                still;
   logic                div_start;
   logic signed [WORD_W:0] diff [NUM_ACCEL];
   logic [WORD_W:0]     mag [NUM_ACCEL];

   // Stillness: every accel axis moved less than the threshold since the last sample.
   always_comb begin
      still = 1'b1;
      for (int i = 0; i < NUM_ACCEL; i++) begin
         diff[i] = (WORD_W+1)'(sample[ACCEL_BASE+i]) - (WORD_W+1)'(prev_ff[i]);
         mag[i]  = diff[i][WORD_W] ? (WORD_W+1)'(-diff[i]) : (WORD_W+1)'(diff[i]);
         if (!(mag[i] < {1'b0, still_threshold})) begin
            still = 1'b0;
         end
      end
      if (still) begin
         run_next = (run_ff == RUN_MAX) ? run_ff : run_ff + RUN_W'(1);
      end else begin
         run_next = '0;
      end
   end

   // Phase sequencing and accumulation.
   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      run_in    = run_ff;
      count_in  = count_ff;
      sums_in   = sums_ff;
      div_start = 1'b0;
      unique case (phase_ff)
         PHASE_WAIT: begin
            for (int i = 0; i < NUM_ACCEL; i++) begin
               prev_in[i] = sample[ACCEL_BASE+i];
            end
            run_in = run_next;
            if (run_next >= still_run_length) begin
               phase_in = PHASE_AVG;
               count_in = '0;
               sums_in  = '0;
            end
         end
         PHASE_AVG: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               sums_in[i] = sums_ff[i] + SUM_W'(sample[i]);
            end
            sums_in[AXIS_Z_ACCEL] = sums_ff[AXIS_Z_ACCEL] + SUM_W'(sample[AXIS_Z_ACCEL])
                                    - SUM_W'(gravity_reference);
            count_in = count_ff + COUNT_W'(1);
            if (count_in >= COUNT_W'(AVERAGE_SAMPLES)) begin
               count_in  = '0;
               phase_in  = PHASE_DONE;
               div_start = advance;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_WAIT;
         prev_ff  <= '0;
         run_ff   <= '0;
         count_ff <= '0;
         sums_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         sums_ff  <= sums_in;
      end
   end

   assign cal_stat.phase     = phase_ff;
   assign cal_stat.div_start = div_start;
   assign sums               = sums_ff;

   // Once calibrated, the block never leaves that phase.
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_DONE |=> phase_ff == PHASE_DONE)
      else $error("calibrated phase was left");

endmodule

FILE: rtl/ioc_offset_div.sv
module ioc_offset_div
   import ioc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  sum_vec_type  sums,
   output logic         busy,
   output ofs_vec_type  offsets
);

   logic                  issue_ff;
   logic [AXIS_IDX_W-1:0] idx_ff;
   logic                  a_vld_ff, b_vld_ff;
   logic [AXIS_IDX_W-1:0] a_idx_ff, b_idx_ff;
   logic                  a_neg_ff, b_neg_ff;
   logic [SUM_W-1:0]      a_mag_ff, a_mag_in;
   logic [OFS_W-1:0]      b_quo_ff;
   logic [PROD_W-1:0]     prod;
   sum_type               sel;
   ofs_vec_type           ofs_ff;

   // Stage A picks one sum and takes its magnitude.
   always_comb begin
      sel      = sums[idx_ff];
      a_mag_in = sel[SUM_W-1] ? SUM_W'(-sel) : SUM_W'(sel);
   end

   // Stage B: quotient by reciprocal multiply.
   assign prod = PROD_W'(a_mag_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         idx_ff   <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (start) begin
            issue_ff <= 1'b1;
            idx_ff   <= '0;
         end else if (issue_ff) begin
            if (idx_ff == AXIS_IDX_W'(NUM_AXES - 1)) begin
               issue_ff <= 1'b0;
               idx_ff   <= '0;
            end else begin
               idx_ff <= idx_ff + AXIS_IDX_W'(1);
            end
         end
         a_vld_ff <= issue_ff;
         b_vld_ff <= a_vld_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      a_mag_ff <= a_mag_in;
      a_neg_ff <= sel[SUM_W-1];
      a_idx_ff <= idx_ff;
      b_quo_ff <= prod[RECIP_SHIFT +: OFS_W];
      b_neg_ff <= a_neg_ff;
      b_idx_ff <= a_idx_ff;
   end

   // Stage C restores the sign, so the quotient truncates toward zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff <= '0;
      end else if (b_vld_ff) begin
         ofs_ff[b_idx_ff] <= b_neg_ff ? OFS_W'(-b_quo_ff) : b_quo_ff;
      end
   end

   assign busy    = issue_ff | a_vld_ff | b_vld_ff;
   assign offsets = ofs_ff;

   // A start pass keeps the unit busy in the following cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("divider did not start");

endmodule

FILE: rtl/imu_offset_calibrator_unit.sv
// IMU offset calibrator.
// One six-axis sample enters on the req_ channel per transaction; each one
// gives exactly one rsp_ transaction holding every axis minus its offset
// (wrapped to 16 bits) and the calibration phase in which it was handled.
// The block first waits for a run of still samples, then averages the next
// 100 samples into six offsets; offsets stay zero until then.
// A sample is captured in the input register, then processed into the result
// register. Throughput is one transaction per cycle while rsp_stall is low and
// the offset divider is idle. After the last averaging sample, the offset
// divider (one shared reciprocal multiplier, one axis per cycle, three stages)
// blocks sample processing while it works; this happens once per reset.
// A stalled result holds in the result register; the input register still
// takes one more sample, after which req_stall rises.
// Synchronous reset restores the configuration registers to their defaults,
// returns to the waiting phase and clears the offsets. csr_ writes take effect
// at the next sample and should be made while no transaction is in flight.
module imu_offset_calibrator_unit
   import ioc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [WORD_W-1:0] req_gyro_x_raw,
   input  logic signed [WORD_W-1:0] req_gyro_y_raw,
   input  logic signed [WORD_W-1:0] req_gyro_z_raw,
   input  logic signed [WORD_W-1:0] req_accel_x_raw,
   input  logic signed [WORD_W-1:0] req_accel_y_raw,
   input  logic signed [WORD_W-1:0] req_accel_z_raw,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WORD_W-1:0] rsp_gyro_x_out,
   output logic signed [WORD_W-1:0] rsp_gyro_y_out,
   output logic signed [WORD_W-1:0] rsp_gyro_z_out,
   output logic signed [WORD_W-1:0] rsp_accel_x_out,
   output logic signed [WORD_W-1:0] rsp_accel_y_out,
   output logic signed [WORD_W-1:0] rsp_accel_z_out,
   output logic [1:0]              rsp_cal_phase,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [THRESHOLD_W-1:0] thr_ff;
   logic [RUN_W-1:0]       run_len_ff;
   logic [GRAVITY_W-1:0]   grav_ff;
   logic                   s1_valid_ff;
   word_vec_type           s1_sample_ff;
   logic                   rsp_valid_ff;
   word_vec_type           rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_phase_ff;
   logic                   accept, advance, out_free, div_busy;
   calib_status_type       cal_stat;
   sum_vec_type            sums;
   ofs_vec_type            offsets;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THRESHOLD_RESET;
         run_len_ff <= RUN_LENGTH_RESET;
         grav_ff    <= GRAVITY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STILL_THRESHOLD:   thr_ff     <= csr_wdata[THRESHOLD_W-1:0];
            CSR_STILL_RUN_LENGTH:  run_len_ff <= csr_wdata[RUN_W-1:0];
            CSR_GRAVITY_REFERENCE: grav_ff    <= csr_wdata[GRAVITY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the input register moves on when the result slot frees up and the divider is idle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free && !div_busy;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept || (s1_valid_ff && !advance);
         rsp_valid_ff <= advance || (rsp_valid_ff && rsp_stall);
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= {req_accel_z_raw, req_accel_y_raw, req_accel_x_raw,
                          req_gyro_z_raw, req_gyro_y_raw, req_gyro_x_raw};
      end
   end

   ioc_calib_core u_core (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .sample            (s1_sample_ff),
      .still_threshold   (thr_ff),
      .still_run_length  (run_len_ff),
      .gravity_reference (grav_ff),
      .cal_stat          (cal_stat),
      .sums              (sums)
   );

   ioc_offset_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cal_stat.div_start),
      .sums    (sums),
      .busy    (div_busy),
      .offsets (offsets)
   );

   // Offset removal, wrapping to the sensor word width.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         rsp_data_in[i] = s1_sample_ff[i] - offsets[i][WORD_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_phase_ff <= cal_stat.phase;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gyro_x_out  = rsp_data_ff[0];
   assign rsp_gyro_y_out  = rsp_data_ff[1];
   assign rsp_gyro_z_out  = rsp_data_ff[2];
   assign rsp_accel_x_out = rsp_data_ff[3];
   assign rsp_accel_y_out = rsp_data_ff[4];
   assign rsp_accel_z_out = rsp_data_ff[5];
   assign rsp_cal_phase   = rsp_phase_ff;

   // No sample is processed while offsets are still being computed.
   a_no_advance_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !advance)
      else $error("sample processed during offset division");

   // An empty input register never pushes back.
   a_stall_needs_data: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("stall raised with empty input register");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ioc_pkg::*;

   // Index 3 maps to no register and must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int MAX_GAP       = 10;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 5000;

   // Ways of stepping the accelerometer while hunting for stillness.
   typedef enum int {STEP_BREAK, STEP_EDGE_IN, STEP_EDGE_OUT, STEP_DRIFT} step_kind_type;

   typedef struct {
      word_vec_type axes;
      logic [1:0]   phase;
   } corrected_type;

   // Tracks calibration state and queues the corrected samples in order.
   class calibration_tracker;
      logic [THRESHOLD_W-1:0] threshold;
      logic [RUN_W-1:0]       run_length;
      logic [GRAVITY_W-1:0]   gravity;
      logic [1:0]             phase;
      word_type               prev_accel [NUM_ACCEL];
      logic [RUN_W-1:0]       still_run;
      logic [COUNT_W-1:0]     avg_count;
      sum_vec_type            sums;
      ofs_vec_type            offsets;
      corrected_type          corrected_queue [$];
      string                  axis_names [NUM_AXES];
      int                     errors;

      function new();
         threshold = THRESHOLD_RESET;
         run_length = RUN_LENGTH_RESET;
         gravity = GRAVITY_RESET;
         phase = PHASE_WAIT;
         still_run = '0;
         avg_count = '0;
         sums = '0;
         offsets = '0;
         errors = 0;
         foreach (prev_accel[i]) prev_accel[i] = '0;
         axis_names = '{"gyro_x_out", "gyro_y_out", "gyro_z_out",
                        "accel_x_out", "accel_y_out", "accel_z_out"};
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_STILL_THRESHOLD:   threshold = data[THRESHOLD_W-1:0];
            CSR_STILL_RUN_LENGTH:  run_length = data[RUN_W-1:0];
            CSR_GRAVITY_REFERENCE: gravity = data[GRAVITY_W-1:0];
            default: ;
         endcase
      endfunction

      // Queue the corrected sample, then advance the calibration state.
      function void note_sample(word_vec_type smp);
         corrected_type expd;
         logic still;
         int diff;
         for (int i = 0; i < NUM_AXES; i++)
            expd.axes[i] = smp[i] - offsets[i][WORD_W-1:0];
         expd.phase = phase;
         corrected_queue.push_back(expd);

         if (phase == PHASE_WAIT) begin
            still = 1'b1;
            for (int i = 0; i < NUM_ACCEL; i++) begin
               diff = int'($signed(smp[ACCEL_BASE + i])) - int'(prev_accel[i]);
               if (diff < 0) diff = -diff;
               if (diff >= int'(threshold)) still = 1'b0;
               prev_accel[i] = smp[ACCEL_BASE + i];
            end
            if (!still) begin
               still_run = '0;
            end else if (still_run != RUN_MAX) begin
               still_run = still_run + 1'b1;
            end
            if (still_run >= run_length) begin
               phase = PHASE_AVG;
               avg_count = '0;
               sums = '0;
            end
         end else if (phase == PHASE_AVG) begin
            for (int i = 0; i < NUM_AXES; i++)
               sums[i] = $signed(sums[i]) + $signed(smp[i]);
            sums[AXIS_Z_ACCEL] = $signed(sums[AXIS_Z_ACCEL]) - $signed({1'b0, gravity});
            avg_count = avg_count + 1'b1;
            // Division truncates toward zero, as signed division does here.
            if (avg_count >= AVERAGE_SAMPLES) begin
               for (int i = 0; i < NUM_AXES; i++)
                  offsets[i] = OFS_W'($signed(sums[i]) / AVERAGE_SAMPLES);
               avg_count = '0;
               phase = PHASE_DONE;
            end
         end
      endfunction

      function void check_output(corrected_type got);
         corrected_type expd;
         if (corrected_queue.size() == 0) begin
            $error("output transaction with no sample pending");
            errors++;
            return;
         end
         expd = corrected_queue.pop_front();
         for (int i = 0; i < NUM_AXES; i++) begin
            if (got.axes[i] !== expd.axes[i]) begin
               $error("%s: expected %0d, got %0d", axis_names[i],
                      $signed(expd.axes[i]), $signed(got.axes[i]));
               errors++;
            end
         end
         if (got.phase !== expd.phase) begin
            $error("cal_phase: expected %0d, got %0d", expd.phase, got.phase);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   word_type               req_gyro_x_raw = '0;
   word_type               req_gyro_y_raw = '0;
   word_type               req_gyro_z_raw = '0;
   word_type               req_accel_x_raw = '0;
   word_type               req_accel_y_raw = '0;
   word_type               req_accel_z_raw = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   word_type               rsp_gyro_x_out;
   word_type               rsp_gyro_y_out;
   word_type               rsp_gyro_z_out;
   word_type               rsp_accel_x_out;
   word_type               rsp_accel_y_out;
   word_type               rsp_accel_z_out;
   logic [1:0]             rsp_cal_phase;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   calibration_tracker tracker = new();
   int snd_calm = 0;
   int rcv_calm = 0;

   always #10 clock = ~clock;

   imu_offset_calibrator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_gyro_x_raw  (req_gyro_x_raw),
      .req_gyro_y_raw  (req_gyro_y_raw),
      .req_gyro_z_raw  (req_gyro_z_raw),
      .req_accel_x_raw (req_accel_x_raw),
      .req_accel_y_raw (req_accel_y_raw),
      .req_accel_z_raw (req_accel_z_raw),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gyro_x_out  (rsp_gyro_x_out),
      .rsp_gyro_y_out  (rsp_gyro_y_out),
      .rsp_gyro_z_out  (rsp_gyro_z_out),
      .rsp_accel_x_out (rsp_accel_x_out),
      .rsp_accel_y_out (rsp_accel_y_out),
      .rsp_accel_z_out (rsp_accel_z_out),
      .rsp_cal_phase   (rsp_cal_phase),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Idle cycles before the next transaction; now and then a calm stretch with none.
   function automatic int next_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic word_vec_type make_sample(int gx, int gy, int gz, int ax, int ay, int az);
      word_vec_type smp;
      smp[0] = WORD_W'(gx);
      smp[1] = WORD_W'(gy);
      smp[2] = WORD_W'(gz);
      smp[3] = WORD_W'(ax);
      smp[4] = WORD_W'(ay);
      smp[5] = WORD_W'(az);
      return smp;
   endfunction

   function automatic word_vec_type random_sample();
      word_vec_type smp;
      for (int i = 0; i < NUM_AXES; i++)
         smp[i] = WORD_W'($urandom());
      return smp;
   endfunction

   // Offer one sample and hold it until the transaction completes.
   task automatic send_sample(input word_vec_type smp);
      int gap;
      gap = next_gap(snd_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_gyro_x_raw  <= smp[0];
      req_gyro_y_raw  <= smp[1];
      req_gyro_z_raw  <= smp[2];
      req_accel_x_raw <= smp[3];
      req_accel_y_raw <= smp[4];
      req_accel_z_raw <= smp[5];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_sample(smp);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.write_reg(index, data);
      @(posedge clock);
   endtask

   // Stop offering samples and wait until every queued output has arrived.
   task automatic wait_for_outputs();
      int n;
      req_valid <= 1'b0;
      n = 0;
      while (tracker.corrected_queue.size() > 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (tracker.corrected_queue.size() > 0) begin
         $error("%0d output transactions never arrived", tracker.corrected_queue.size());
         tracker.errors++;
         tracker.corrected_queue.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Output side: random stalls, plus two long hold-offs that back up the block.
   initial begin : result_receiver
      corrected_type got;
      int gap;
      int seen;
      seen = 0;
      wait (reset === 1'b0);
      forever begin
         gap = (seen == 60 || seen == 900) ? HOLD_CYCLES : next_gap(rcv_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got.axes[0] = rsp_gyro_x_out;
         got.axes[1] = rsp_gyro_y_out;
         got.axes[2] = rsp_gyro_z_out;
         got.axes[3] = rsp_accel_x_out;
         got.axes[4] = rsp_accel_y_out;
         got.axes[5] = rsp_accel_z_out;
         got.phase = rsp_cal_phase;
         tracker.check_output(got);
         seen++;
      end
   end

   initial begin : watchdog
      #(10_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      word_vec_type  smp;
      step_kind_type kind;
      int target;
      int thr;
      int axis;
      int d;
      int r;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed samples under the reset settings. The first one is compared
      // against the cleared previous accelerometer values.
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      send_sample(make_sample(21845, 21845, 21845, 21845, 21845, 21845));
      send_sample(make_sample(-21846, -21846, -21846, -21846, -21846, -21846));
      // Accelerometer steps just inside and exactly on the threshold.
      send_sample(make_sample(1, -1, 0, -21447, -22245, -21447));
      send_sample(make_sample(0, 0, 0, -21047, -22245, -21447));
      send_sample(make_sample(7, 8, 9, -21047, -22245, -21447));
      send_sample(make_sample(0, 0, 0, -21047, -22645, -21447));
      send_sample(make_sample(0, 0, 0, -21047, -22645, -21847));
      send_sample(make_sample(32767, -32768, 0, -21047, -22645, -21847));
      send_sample(make_sample(-1, 1, -32768, -21046, -22644, -21846));

      // Zero threshold: nothing is still, so random noise never leaves the
      // waiting phase. Upper data bits beyond each register must be dropped.
      wait_for_outputs();
      write_csr(CSR_UNUSED, 16'hFFFF);
      write_csr(CSR_STILL_THRESHOLD, 16'h0000);
      write_csr(CSR_STILL_RUN_LENGTH, {8'hA5, 8'hFF});
      write_csr(CSR_GRAVITY_REFERENCE, 16'h8000);
      repeat (150) send_sample(random_sample());

      // Widest threshold: long still runs, broken by a full-scale jump on
      // accel x. One run stops a single sample short of the required length.
      wait_for_outputs();
      write_csr(CSR_STILL_THRESHOLD, 16'hFFFF);
      for (int run = 0; run < 2; run++) begin
         target = (run == 0) ? 254 : $urandom_range(20, 200);
         while (tracker.still_run < target) begin
            smp = random_sample();
            if (tracker.still_run == target - 1) smp[ACCEL_BASE] = WORD_W'(-32768);
            send_sample(smp);
         end
         smp = random_sample();
         smp[ACCEL_BASE] = WORD_W'(32767);
         send_sample(smp);
      end

      // Moderate threshold: small accelerometer drift with steps right at the
      // threshold and occasional jumps that restart the run.
      wait_for_outputs();
      thr = $urandom_range(50, 4000);
      write_csr(CSR_STILL_THRESHOLD, 16'(thr));
      for (int n = 0; n < 200; n++) begin
         smp = random_sample();
         r = $urandom_range(0, 9);
         kind = (r < 3) ? step_kind_type'(r) : STEP_DRIFT;
         if (tracker.still_run > 200) kind = STEP_BREAK;
         axis = $urandom_range(0, NUM_ACCEL - 1);
         for (int i = 0; i < NUM_ACCEL; i++) begin
            case (kind)
               STEP_BREAK:    d = (i == axis) ? thr + $urandom_range(0, 200)
                                              : $urandom_range(0, thr - 1);
               STEP_EDGE_IN:  d = thr - 1;
               STEP_EDGE_OUT: d = (i == axis) ? thr : 0;
               default:       d = $urandom_range(0, thr - 1);
            endcase
            if ($urandom_range(0, 1) == 1) d = -d;
            if (tracker.prev_accel[i] + d > 32767 || tracker.prev_accel[i] + d < -32768)
               d = -d;
            smp[ACCEL_BASE + i] = WORD_W'(tracker.prev_accel[i] + d);
         end
         send_sample(smp);
      end

      // Zero run length ends the waiting phase on the next sample, even with
      // a zero threshold.
      wait_for_outputs();
      write_csr(CSR_STILL_THRESHOLD, 16'h0000);
      write_csr(CSR_STILL_RUN_LENGTH, {8'h5A, 8'h00});
      send_sample(random_sample());

      // First half of the averaging window, full-scale samples first.
      repeat (3) send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      repeat (3) send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      repeat (44) send_sample(random_sample());

      // Pause mid-window, then finish it with the largest gravity reference.
      wait_for_outputs();
      write_csr(CSR_GRAVITY_REFERENCE, 16'hFFFF);
      while (tracker.phase == PHASE_AVG) send_sample(random_sample());

      // Calibrated: register writes must have no effect any more.
      wait_for_outputs();
      write_csr(CSR_STILL_THRESHOLD, 16'($urandom()));
      write_csr(CSR_STILL_RUN_LENGTH, {8'h00, 8'd1});
      write_csr(CSR_GRAVITY_REFERENCE, 16'($urandom()));
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      repeat (350) send_sample(random_sample());

      wait_for_outputs();
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
